### rtl/ecb_pkg.sv
// Package for the error code blinker: phase codes, register map and widths.
// No dependencies; imported by error_code_blinker_core.
package ecb_pkg;

    localparam int unsigned CODE_W  = 8;
    localparam int unsigned TICK_W  = 8;
    localparam int unsigned PHASE_W = 2;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned OUT_W   = 16;

    // blink phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_LIT   = 2'd1;
    localparam logic [PHASE_W-1:0] PH_DARK  = 2'd2;
    localparam logic [PHASE_W-1:0] PH_PAUSE = 2'd3;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_ON_TICKS    = 2'd0;
    localparam logic [1:0] REG_OFF_TICKS   = 2'd1;
    localparam logic [1:0] REG_PAUSE_TICKS = 2'd2;

    // input kind carried on tuser
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    localparam logic [TICK_W-1:0] ON_TICKS_RST    = 8'd18;
    localparam logic [TICK_W-1:0] OFF_TICKS_RST   = 8'd18;
    localparam logic [TICK_W-1:0] PAUSE_TICKS_RST = 8'd80;
    localparam logic [CODE_W-1:0] BLINKS_MAX      = 8'd255;

endpackage

### rtl/error_code_blinker_core.sv
// Error code blinker: drives a status LED that blinks a stored error code.
// Depends on ecb_pkg for phase codes, register map and widths.
//
// Usage:
//   Input stream (s_axis_*): one transfer per event. tuser = 0 is one timer
//   tick, tuser = 1 writes the error code in tdata[7:0] (zero stops blinking).
//   Output stream (m_axis_*): exactly one result per input transfer, in order:
//   tdata[0] LED level, tdata[8:1] stored code, tdata[10:9] phase
//   (0 idle, 1 lit, 2 dark between blinks, 3 pause).
//   APB port: on_ticks at 0x0, off_ticks at 0x4, pause_ticks at 0x8, 8 bits
//   each; write only while the streams are idle.
// Path: the input transfer is captured in the input register, then the state
//   update is written into the result register once the result side is free
//   (result register empty or being taken).
// Throughput: one item per cycle while the result side does not stall; the
//   state update is a single pass of counter decrement and phase select.
// Reset: LED off, idle phase, code zero, registers at 18/18/80 ticks.
// Stall: when m_axis_tready is low the result holds; the input register
//   still takes one more item, then s_axis_tready drops until the result
//   is taken.
module error_code_blinker_core
    import ecb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] new code (used when mode is 1)
    input  logic              s_axis_tuser,   // [0] mode
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata,   // [0] led_on, [8:1] shown_code,
                                              // [10:9] phase, [15:11] zero
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [TICK_W-1:0]  on_ticks_reg;
    logic [TICK_W-1:0]  off_ticks_reg;
    logic [TICK_W-1:0]  pause_ticks_reg;

    logic               in_valid_reg;
    logic               in_mode_reg;
    logic [CODE_W-1:0]  in_code_reg;

    logic [PHASE_W-1:0] phase_reg,  phase_next;
    logic [TICK_W-1:0]  ticks_reg,  ticks_next;
    logic [CODE_W-1:0]  blinks_reg, blinks_next;
    logic [CODE_W-1:0]  code_reg,   code_next;
    logic               led_reg,    led_next;

    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg;

    logic               advance;
    logic               cfg_write;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_ticks_reg    <= ON_TICKS_RST;
            off_ticks_reg   <= OFF_TICKS_RST;
            pause_ticks_reg <= PAUSE_TICKS_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_ON_TICKS:    on_ticks_reg    <= pwdata[TICK_W-1:0];
                REG_OFF_TICKS:   off_ticks_reg   <= pwdata[TICK_W-1:0];
                REG_PAUSE_TICKS: pause_ticks_reg <= pwdata[TICK_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_ON_TICKS:    prdata[TICK_W-1:0] = on_ticks_reg;
            REG_OFF_TICKS:   prdata[TICK_W-1:0] = off_ticks_reg;
            REG_PAUSE_TICKS: prdata[TICK_W-1:0] = pause_ticks_reg;
            default:         prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_mode_reg <= s_axis_tuser;
            in_code_reg <= s_axis_tdata;
        end
    end

    // ---------------- blink state update ----------------
    always_comb
    begin
        phase_next  = phase_reg;
        ticks_next  = ticks_reg;
        blinks_next = blinks_reg;
        code_next   = code_reg;
        led_next    = led_reg;
        if (in_mode_reg == MODE_TICK)
        begin
            if (ticks_reg != '0)
                ticks_next = ticks_reg - 1'b1;
            else
            begin
                unique case (phase_reg)
                    PH_LIT:
                    begin
                        if (blinks_reg != BLINKS_MAX)
                            blinks_next = blinks_reg + 1'b1;
                        phase_next = PH_DARK;
                        ticks_next = off_ticks_reg;
                        led_next   = 1'b0;
                    end
                    PH_DARK:
                    begin
                        if (blinks_reg >= code_reg)
                        begin
                            phase_next = PH_PAUSE;
                            ticks_next = pause_ticks_reg;
                        end
                        else
                        begin
                            phase_next = PH_LIT;
                            ticks_next = on_ticks_reg;
                            led_next   = 1'b1;
                        end
                    end
                    PH_PAUSE:
                    begin
                        blinks_next = '0;
                        phase_next  = PH_LIT;
                        ticks_next  = on_ticks_reg;
                        led_next    = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
        else
        begin
            if (in_code_reg == '0)
            begin
                phase_next = PH_IDLE;
                led_next   = 1'b0;
            end
            else if (in_code_reg != code_reg)
                phase_next = PH_DARK;
            code_next = in_code_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            ticks_reg  <= '0;
            blinks_reg <= '0;
            code_reg   <= '0;
            led_reg    <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            ticks_reg  <= ticks_next;
            blinks_reg <= blinks_next;
            code_reg   <= code_next;
            led_reg    <= led_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= {5'd0, phase_next, code_next, led_next};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // ---------------- assertions ----------------
    // idle always means a dark LED
    a_idle_dark: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> !led_reg)
        else $error("LED lit in idle phase");

    // lit phase is only entered with the LED turned on
    a_lit_on: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LIT |-> led_reg)
        else $error("LED dark in lit phase");

    // a zero code leaves nothing to blink
    a_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        code_reg == '0 |-> phase_reg == PH_IDLE)
        else $error("blinking with zero code");

    // a held input item is not dropped while the result side stalls
    a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_code_reg))
        else $error("input item lost during stall");

endmodule
